[src/u2fr_pkg.sv]
// shared types and constants for the hid response reassembler
`default_nettype none
package u2fr_pkg;

	localparam int unsigned REPORT_BYTES    = 64;
	localparam int unsigned POS_W           = $clog2(REPORT_BYTES + 1);
	localparam int unsigned INIT_DATA_START = 7;
	localparam int unsigned CHAN_ID_BYTES   = 4;
	localparam int unsigned CMD_POS         = 4;
	localparam int unsigned COUNT_HI_POS    = 5;
	localparam int unsigned COUNT_LO_POS    = 6;

	localparam logic [31:0] CHANNEL_ID_RESET = 32'hFFFF_FFFF;

	// register select, taken from paddr bit 2
	localparam logic REG_CHANNEL_ID = 1'b0;

	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_EMPTY = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_INIT = 2'd1;
	localparam logic [1:0] ERR_SEQ  = 2'd2;

	typedef struct packed {
		logic       valid;
		logic [1:0] kind;
		logic [7:0] data;
		logic [6:0] command;
		logic       last;
		logic [1:0] error_code;
	} result_t;

endpackage
`default_nettype wire

[src/u2fr_frame.sv]
// frame tracking state and per-beat result decode
`default_nettype none
module u2fr_frame
	import u2fr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        fire,
	input  wire logic [7:0]  report_byte,
	input  wire logic        report_start,
	input  wire logic [31:0] channel_id,
	output result_t          res
);

	logic             collecting_q, collecting_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic             chan_match_q, chan_match_d;
	logic             is_init_q, is_init_d;
	logic             ignored_q, ignored_d;
	logic [15:0]      remaining_q, remaining_d;
	logic [7:0]       exp_seq_q, exp_seq_d;
	logic [6:0]       cmd_q, cmd_d;
	logic [7:0]       count_hi_q, count_hi_d;

	logic [POS_W-1:0] p;
	logic [7:0]       want;
	logic [15:0]      count;

	always_comb begin
		p = report_start ? '0 : pos_q;
		case (p[1:0])
			2'd0:    want = channel_id[31:24];
			2'd1:    want = channel_id[23:16];
			2'd2:    want = channel_id[15:8];
			default: want = channel_id[7:0];
		endcase
		count = {count_hi_q, report_byte};

		collecting_d = collecting_q;
		pos_d        = p;
		chan_match_d = chan_match_q;
		is_init_d    = is_init_q;
		ignored_d    = ignored_q;
		remaining_d  = remaining_q;
		exp_seq_d    = exp_seq_q;
		cmd_d        = cmd_q;
		count_hi_d   = count_hi_q;

		res            = '0;
		res.command    = cmd_q;

		if (p < POS_W'(REPORT_BYTES)) begin
			pos_d = p + POS_W'(1);
			if (p < POS_W'(CHAN_ID_BYTES)) begin
				if (p == '0) begin
					chan_match_d = (report_byte == want);
					is_init_d    = 1'b0;
					ignored_d    = 1'b0;
				end else if (report_byte != want) begin
					chan_match_d = 1'b0;
				end
			end else if (p == POS_W'(CMD_POS)) begin
				if (!chan_match_q) begin
					ignored_d = 1'b1;
				end else begin
					is_init_d = report_byte[7];
					if (!collecting_q) begin
						if (!report_byte[7]) begin
							ignored_d = 1'b1;
						end else begin
							cmd_d = report_byte[6:0];
						end
					end else if (report_byte[7]) begin
						// init frame in the middle of a message
						collecting_d   = 1'b0;
						ignored_d      = 1'b1;
						res.valid      = 1'b1;
						res.kind       = KIND_ERROR;
						res.last       = 1'b1;
						res.error_code = ERR_INIT;
					end else if (report_byte != exp_seq_q) begin
						collecting_d   = 1'b0;
						ignored_d      = 1'b1;
						res.valid      = 1'b1;
						res.kind       = KIND_ERROR;
						res.last       = 1'b1;
						res.error_code = ERR_SEQ;
					end else begin
						exp_seq_d = exp_seq_q + 8'd1;
					end
				end
			end else if (!ignored_q) begin
				if (is_init_q && p < POS_W'(INIT_DATA_START)) begin
					if (p == POS_W'(COUNT_HI_POS)) begin
						count_hi_d = report_byte;
					end else begin
						remaining_d = count;
						exp_seq_d   = '0;
						if (count == '0) begin
							collecting_d = 1'b0;
							res.valid    = 1'b1;
							res.kind     = KIND_EMPTY;
							res.last     = 1'b1;
						end else begin
							collecting_d = 1'b1;
						end
					end
				end else if (collecting_q && remaining_q != '0) begin
					remaining_d = remaining_q - 16'd1;
					res.valid   = 1'b1;
					res.kind    = KIND_DATA;
					res.data    = report_byte;
					if (remaining_q == 16'd1) begin
						collecting_d = 1'b0;
						res.last     = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collecting_q <= 1'b0;
			pos_q        <= '0;
			chan_match_q <= 1'b1;
			is_init_q    <= 1'b0;
			ignored_q    <= 1'b0;
			remaining_q  <= '0;
			exp_seq_q    <= '0;
			cmd_q        <= '0;
			count_hi_q   <= '0;
		end else if (fire) begin
			collecting_q <= collecting_d;
			pos_q        <= pos_d;
			chan_match_q <= chan_match_d;
			is_init_q    <= is_init_d;
			ignored_q    <= ignored_d;
			remaining_q  <= remaining_d;
			exp_seq_q    <= exp_seq_d;
			cmd_q        <= cmd_d;
			count_hi_q   <= count_hi_d;
		end
	end

endmodule
`default_nettype wire

[src/u2f_hid_response_reassembler_top.sv]
// top level: register port, frame tracker and output skid stage
`default_nettype none
// Takes one HID report byte per beat and rebuilds one message: bytes 0..3 are
// the channel id (compared with channel_id, first byte in bits 31..24), byte 4
// is the command or sequence number, an init frame carries a 16-bit count in
// bytes 5 and 6. Each payload byte comes out as a result beat of kind 0, the
// final one with last set; an empty message gives one kind 1 beat and errors
// give a kind 2 beat. A byte is taken every cycle while report_stall is low:
// its decode sits between the input port and the result register, so a
// result beat is registered into the output register, or into a one-entry
// skid register that holds a second result while the first one is stalled,
// so bytes keep flowing until two results are waiting. report_stall rises
// only when that skid entry is occupied. channel_id sits at byte address 0
// and should be written only while the block is idle.
module u2f_hid_response_reassembler_top
	import u2fr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        report_valid,
	output logic             report_stall,
	input  wire logic [7:0]  report_byte,
	input  wire logic        report_start,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic      [1:0]  kind,
	output logic      [7:0]  data,
	output logic      [6:0]  command,
	output logic             last,
	output logic      [1:0]  error_code
);

	logic [31:0] channel_id_q;
	logic        fire;
	result_t     res;
	result_t     out_q;
	result_t     skid_q;
	logic        take;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CHANNEL_ID) ? channel_id_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_id_q <= CHANNEL_ID_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_CHANNEL_ID) begin
			channel_id_q <= pwdata;
		end
	end

	assign report_stall = skid_q.valid;
	assign fire         = report_valid && !report_stall;

	u2fr_frame u_frame (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.report_byte  (report_byte),
		.report_start (report_start),
		.channel_id   (channel_id_q),
		.res          (res)
	);

	assign take = !out_q.valid || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q  <= '0;
			skid_q <= '0;
		end else if (take) begin
			// skid entry drains first; no new beat is taken while it is full
			out_q.valid  <= skid_q.valid || (fire && res.valid);
			skid_q.valid <= 1'b0;
			if (skid_q.valid) begin
				out_q.kind       <= skid_q.kind;
				out_q.data       <= skid_q.data;
				out_q.command    <= skid_q.command;
				out_q.last       <= skid_q.last;
				out_q.error_code <= skid_q.error_code;
			end else begin
				out_q.kind       <= res.kind;
				out_q.data       <= res.data;
				out_q.command    <= res.command;
				out_q.last       <= res.last;
				out_q.error_code <= res.error_code;
			end
		end else if (fire && res.valid) begin
			skid_q.valid      <= 1'b1;
			skid_q.kind       <= res.kind;
			skid_q.data       <= res.data;
			skid_q.command    <= res.command;
			skid_q.last       <= res.last;
			skid_q.error_code <= res.error_code;
		end
	end

	assign result_valid = out_q.valid;
	assign kind         = out_q.kind;
	assign data         = out_q.data;
	assign command      = out_q.command;
	assign last         = out_q.last;
	assign error_code   = out_q.error_code;

endmodule
`default_nettype wire

[bench/u2f_hid_response_reassembler_top_tb.sv]
// self-checking bench for the hid response reassembler: stimulus, byte driver, result checker
`default_nettype none
module u2f_hid_response_reassembler_top_tb
	import u2fr_pkg::*;
();

	localparam int unsigned SETTLE         = 8;
	localparam int unsigned WATCHDOG_LIMIT = 400;
	localparam int unsigned PHASE_BYTES    = 120;
	localparam int unsigned CONT_DATA_POS  = CMD_POS + 1;
	localparam logic [2:0]  CHANNEL_ID_ADDR = {REG_CHANNEL_ID, 2'b00};

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [6:0] command;
		logic       last;
		logic [1:0] error_code;
	} beat_t;

	typedef struct {
		logic [7:0] octet;
		logic       mark;
		bit         hold;
	} report_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        report_valid = 1'b0;
	logic        report_stall;
	logic [7:0]  report_byte = '0;
	logic        report_start = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  data;
	logic [6:0]  command;
	logic        last;
	logic [1:0]  error_code;

	u2f_hid_response_reassembler_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.report_valid (report_valid),
		.report_stall (report_stall),
		.report_byte  (report_byte),
		.report_start (report_start),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.kind         (kind),
		.data         (data),
		.command      (command),
		.last         (last),
		.error_code   (error_code)
	);

	always #4 clk = ~clk;

	// tracked copy of the reassembler state
	logic [31:0] chan_cfg = CHANNEL_ID_RESET;
	bit          rx_collecting = 1'b0;
	int unsigned rx_pos = 0;
	bit          rx_chan_ok = 1'b1;
	bit          rx_is_init = 1'b0;
	bit          rx_skip = 1'b0;
	logic [15:0] rx_remaining = '0;
	logic [7:0]  rx_seq = '0;
	logic [6:0]  rx_cmd = '0;
	logic [7:0]  rx_count_hi = '0;

	report_item_t tx_bytes[$];
	beat_t        expected_beats[$];

	logic [7:0]  frame [0:REPORT_BYTES+7];
	bit          hold_next = 1'b0;
	bit          sender_calm = 1'b0;
	bit          receiver_calm = 1'b0;
	int unsigned send_gap = 0;
	int unsigned recv_wait = 0;
	int unsigned quiet = 0;
	int unsigned n_queued = 0;
	int unsigned n_sent = 0;
	int unsigned n_mismatch = 0;
	int unsigned n_settings = 0;
	int unsigned n_kind [0:3] = '{0, 0, 0, 0};

	// one report byte through the message rebuild; returns 1 when it yields a beat
	function automatic bit reassemble_step(input logic [7:0] b, input logic st,
			output beat_t r);
		int unsigned p;
		r = '0;
		r.command = rx_cmd;
		if (st)
			rx_pos = 0;
		p = rx_pos;
		if (p >= REPORT_BYTES)
			return 1'b0;
		rx_pos = p + 1;
		if (p < CHAN_ID_BYTES) begin
			if (p == 0) begin
				rx_chan_ok = (b == chan_cfg[8*(3-p) +: 8]);
				rx_is_init = 1'b0;
				rx_skip = 1'b0;
			end else if (b != chan_cfg[8*(3-p) +: 8]) begin
				rx_chan_ok = 1'b0;
			end
			return 1'b0;
		end
		if (p == CMD_POS) begin
			if (!rx_chan_ok) begin
				rx_skip = 1'b1;
				return 1'b0;
			end
			rx_is_init = b[7];
			if (!rx_collecting) begin
				if (!rx_is_init) begin
					rx_skip = 1'b1;
					return 1'b0;
				end
				rx_cmd = b[6:0];
				return 1'b0;
			end
			if (rx_is_init || b != rx_seq) begin
				rx_collecting = 1'b0;
				rx_skip = 1'b1;
				r.kind = KIND_ERROR;
				r.last = 1'b1;
				r.error_code = rx_is_init ? ERR_INIT : ERR_SEQ;
				return 1'b1;
			end
			rx_seq = rx_seq + 8'd1;
			return 1'b0;
		end
		if (rx_skip)
			return 1'b0;
		if (rx_is_init && p < INIT_DATA_START) begin
			if (p == COUNT_HI_POS) begin
				rx_count_hi = b;
				return 1'b0;
			end
			rx_remaining = {rx_count_hi, b};
			rx_seq = '0;
			if (rx_remaining == 0) begin
				rx_collecting = 1'b0;
				r.kind = KIND_EMPTY;
				r.last = 1'b1;
				return 1'b1;
			end
			rx_collecting = 1'b1;
			return 1'b0;
		end
		if (!rx_collecting || rx_remaining == 0)
			return 1'b0;
		rx_remaining = rx_remaining - 16'd1;
		r.kind = KIND_DATA;
		r.data = b;
		r.last = (rx_remaining == 0);
		if (rx_remaining == 0)
			rx_collecting = 1'b0;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		if (n_mismatch < 20)
			$display("mismatch at %0t: %s is %0h, expected %0h", $time, what, got, want);
		n_mismatch++;
	endtask

	// byte driver: one beat per accepted byte, random gap before the next
	always @(posedge clk) begin : drive_bytes
		int unsigned g;
		beat_t b;
		if (!arst_n) begin
			report_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			g = send_gap;
			if (report_valid && !report_stall) begin
				n_sent++;
				if (reassemble_step(report_byte, report_start, b))
					expected_beats.push_back(b);
				if ($urandom_range(0, 31) == 0)
					sender_calm = !sender_calm;
				g = sender_calm ? 0 : $urandom_range(0, 7);
			end
			if (!report_valid || !report_stall) begin
				if (g == 0 && tx_bytes.size() != 0 &&
						!(tx_bytes[0].hold && expected_beats.size() != 0)) begin
					report_byte <= tx_bytes[0].octet;
					report_start <= tx_bytes[0].mark;
					report_valid <= 1'b1;
					void'(tx_bytes.pop_front());
				end else begin
					report_valid <= 1'b0;
					if (g != 0)
						g--;
				end
			end
			send_gap <= g;
		end
	end

	// result checker with random back-pressure
	always @(posedge clk) begin : check_results
		int unsigned s;
		beat_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
			recv_wait <= 0;
		end else begin
			s = recv_wait;
			if (result_valid && !result_stall) begin
				if (expected_beats.size() == 0) begin
					report_mismatch("unexpected beat, kind", kind, 0);
				end else begin
					want = expected_beats.pop_front();
					n_kind[want.kind]++;
					if (kind !== want.kind)
						report_mismatch("kind", kind, want.kind);
					if (data !== want.data)
						report_mismatch("data", data, want.data);
					if (command !== want.command)
						report_mismatch("command", command, want.command);
					if (last !== want.last)
						report_mismatch("last", last, want.last);
					if (error_code !== want.error_code)
						report_mismatch("error_code", error_code, want.error_code);
				end
				if ($urandom_range(0, 31) == 0)
					receiver_calm = !receiver_calm;
				s = receiver_calm ? 0 : $urandom_range(0, 7);
			end else if (s != 0) begin
				s--;
			end
			result_stall <= (s != 0);
			recv_wait <= s;
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || psel || (report_valid && !report_stall) ||
				(result_valid && !result_stall)) begin
			quiet <= 0;
		end else if (quiet >= WATCHDOG_LIMIT) begin
			$display("no progress for %0d cycles, %0d beats outstanding", quiet,
				expected_beats.size());
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic m);
		report_item_t it;
		it.octet = b;
		it.mark = m;
		it.hold = hold_next;
		hold_next = 1'b0;
		tx_bytes.push_back(it);
		n_queued++;
	endtask

	task automatic put_id(input logic [31:0] id);
		frame[0] = id[31:24];
		frame[1] = id[23:16];
		frame[2] = id[15:8];
		frame[3] = id[7:0];
	endtask

	task automatic fill_payload(input int unsigned from, input int unsigned upto);
		int unsigned k;
		for (k = from; k < upto; k++)
			frame[k] = 8'($urandom_range(0, 255));
	endtask

	task automatic emit_frame(input int unsigned len, input logic marked);
		int unsigned k;
		for (k = 0; k < len; k++)
			push_byte(frame[k], k == 0 ? marked : 1'b0);
	endtask

	// mostly short reports, some full ones, a few overrunning without a start mark
	function automatic int unsigned pick_len(input int unsigned lo);
		int unsigned r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return REPORT_BYTES + $urandom_range(1, 8);
		if (r < 3)
			return REPORT_BYTES;
		return $urandom_range(lo, 20);
	endfunction

	function automatic int unsigned room(input int unsigned len, input int unsigned from);
		int unsigned n;
		n = len > REPORT_BYTES ? REPORT_BYTES : len;
		return n > from ? n - from : 0;
	endfunction

	task automatic queue_message();
		int cnt, left;
		int unsigned len, seq;
		bit faulty;
		case ($urandom_range(0, 7))
			0: cnt = 0;
			1: cnt = $urandom_range(0, 16'hFFFF);
			default: cnt = $urandom_range(1, 60);
		endcase
		faulty = (cnt > 150) || ($urandom_range(0, 5) == 0);
		hold_next = ($urandom_range(0, 15) == 0);
		put_id(chan_cfg);
		frame[4] = 8'h80 | 8'($urandom_range(0, 127));
		frame[5] = cnt[15:8];
		frame[6] = cnt[7:0];
		len = pick_len(INIT_DATA_START + 1);
		fill_payload(INIT_DATA_START, len);
		emit_frame(len, 1'b1);
		left = cnt - room(len, INIT_DATA_START);
		seq = 0;
		while (left > 0) begin
			if (faulty && $urandom_range(0, 2) == 0) begin
				// abort by a fresh init frame or a bad sequence number
				put_id(chan_cfg);
				if ($urandom_range(0, 1) == 1) begin
					frame[4] = 8'h80 | 8'($urandom_range(0, 127));
				end else begin
					frame[4] = 8'($urandom_range(0, 127));
					if (frame[4] == seq[7:0])
						frame[4] = frame[4] ^ 8'h01;
				end
				len = pick_len(CONT_DATA_POS);
				fill_payload(CONT_DATA_POS, len);
				emit_frame(len, 1'b1);
				return;
			end
			if ($urandom_range(0, 7) == 0) begin
				// foreign channel report in between, off by one bit
				put_id(chan_cfg ^ (32'h1 << $urandom_range(0, 31)));
				frame[4] = 8'($urandom_range(0, 255));
				len = pick_len(CONT_DATA_POS);
				fill_payload(CONT_DATA_POS, len);
				emit_frame(len, 1'b1);
			end
			put_id(chan_cfg);
			frame[4] = seq[7:0];
			len = pick_len(CONT_DATA_POS + 1);
			fill_payload(CONT_DATA_POS, len);
			emit_frame(len, 1'b1);
			left -= room(len, CONT_DATA_POS);
			seq++;
		end
	endtask

	// stray reports: continuation frames while waiting, foreign ids, odd start marks
	task automatic queue_noise();
		int unsigned len, k;
		len = $urandom_range(1, 24);
		put_id($urandom_range(0, 1) == 1 ? chan_cfg : $urandom);
		frame[4] = 8'($urandom_range(0, 127));
		fill_payload(CONT_DATA_POS, len);
		for (k = 0; k < len; k++)
			push_byte(frame[k], k == 0 ? ($urandom_range(0, 3) != 0)
				: ($urandom_range(0, 15) == 0));
	endtask

	task automatic wait_idle();
		while (tx_bytes.size() != 0 || report_valid || expected_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_channel(input logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CHANNEL_ID_ADDR;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		chan_cfg = v;
		n_settings++;
	endtask

	initial begin : run
		logic [31:0] settings [0:3];
		int unsigned ph, mark;
		settings[0] = 32'h0000_0000;
		settings[1] = $urandom;
		settings[2] = 32'hFFFF_FFFF;
		settings[3] = $urandom;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// empty message with top command, first byte unmarked after reset
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		// one zero payload byte under command 0, held until the empty beat is back
		hold_next = 1'b1;
		put_id(CHANNEL_ID_RESET);
		frame[4] = 8'h80;
		frame[5] = 8'h00;
		frame[6] = 8'h01;
		frame[7] = 8'h00;
		emit_frame(INIT_DATA_START + 1, 1'b1);
		// continuation frame while waiting is skipped
		frame[4] = 8'h00;
		emit_frame(CONT_DATA_POS, 1'b1);
		wait_idle();

		for (ph = 0; ph < 4; ph++) begin
			write_channel(settings[ph]);
			mark = n_queued;
			while (n_queued - mark < PHASE_BYTES) begin
				if ($urandom_range(0, 9) == 0)
					queue_noise();
				else
					queue_message();
			end
			wait_idle();
		end

		$display("sent %0d report bytes under %0d channel id settings", n_sent, n_settings);
		$display("checked beats: %0d payload, %0d empty message, %0d error",
			n_kind[KIND_DATA], n_kind[KIND_EMPTY], n_kind[KIND_ERROR]);
		if (n_mismatch == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
`default_nettype wire

[sim.f]
src/u2fr_pkg.sv
src/u2fr_frame.sv
src/u2f_hid_response_reassembler_top.sv
bench/u2f_hid_response_reassembler_top_tb.sv
